// ----- rtl/core/order_command_line_parser_defines.svh -----
// Assertion macros for the order command line parser.
`ifndef ORDER_COMMAND_LINE_PARSER_DEFINES_SVH
`define ORDER_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OCL_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OCL_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/ocl_pkg.sv -----
// Types and constants shared by the order command line parser modules.
package ocl_pkg;

    localparam logic [1:0] EV_ADD    = 2'd0;
    localparam logic [1:0] EV_CANCEL = 2'd1;
    localparam logic [1:0] EV_PRINT  = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN = 3'd1;
    localparam logic [2:0] ERR_MISSING = 3'd2;
    localparam logic [2:0] ERR_ID      = 3'd3;
    localparam logic [2:0] ERR_SIDE    = 3'd4;
    localparam logic [2:0] ERR_PRICE   = 3'd5;
    localparam logic [2:0] ERR_QTY     = 3'd6;

    // token positions on a line
    localparam logic [2:0] TOK_CMD   = 3'd0;
    localparam logic [2:0] TOK_ID    = 3'd1;
    localparam logic [2:0] TOK_SIDE  = 3'd2;
    localparam logic [2:0] TOK_PRICE = 3'd3;
    localparam logic [2:0] TOK_QTY   = 3'd4;
    localparam logic [2:0] TOK_MAX   = 3'd7;

    // bits of the field error flags
    localparam logic [1:0] EB_ID    = 2'd0;
    localparam logic [1:0] EB_SIDE  = 2'd1;
    localparam logic [1:0] EB_PRICE = 2'd2;
    localparam logic [1:0] EB_QTY   = 2'd3;

    // keyword candidate bits
    localparam int KW_ADD    = 0;
    localparam int KW_CANCEL = 1;
    localparam int KW_PRINT  = 2;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [7:0] KW_CH [3][8] = '{
        '{8'h41, 8'h44, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // ADD
        '{8'h43, 8'h41, 8'h4E, 8'h43, 8'h45, 8'h4C, 8'h00, 8'h00},   // CANCEL
        '{8'h50, 8'h52, 8'h49, 8'h4E, 8'h54, 8'h00, 8'h00, 8'h00}    // PRINT
    };
    localparam logic [2:0] KW_LEN [3] = '{3'd3, 3'd6, 3'd5};

    localparam logic [7:0] SIDE_CH [4][8] = '{
        '{8'h42, 8'h55, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // BUY
        '{8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},   // B
        '{8'h53, 8'h45, 8'h4C, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00},   // SELL
        '{8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}    // S
    };
    localparam logic [2:0] SIDE_LEN [4] = '{3'd3, 3'd1, 3'd4, 3'd1};

    // line flags at the end of a character, after any token is closed
    typedef struct packed {
        logic [2:0] tok;
        logic       skip;
        logic [2:0] kw;
        logic [3:0] side;
        logic [2:0] neg;
        logic [3:0] err;
    } line_sum_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [2:0]        error_code;
        logic signed [31:0] order_id;
        logic              side;
        logic signed [31:0] price;
        logic signed [31:0] quantity;
    } result_t;

endpackage

// ----- rtl/core/ocl_dacc.sv -----
// Decimal digit accumulator: mag * 10 + digit, saturating just above the limit.
module ocl_dacc #(
    parameter int MAG_WIDTH = 33
) (
    input  logic [MAG_WIDTH-1:0] mag_in,
    input  logic [3:0]           digit,
    output logic [MAG_WIDTH-1:0] mag_out
);
    localparam int PW = MAG_WIDTH + 4;
    localparam logic [MAG_WIDTH-1:0] LIM = {2'b01, {(MAG_WIDTH-2){1'b0}}};
    localparam logic [MAG_WIDTH-1:0] CAP = LIM + MAG_WIDTH'(1);

    logic [PW-1:0] prod;

    // x10 as x8 + x2
    assign prod = PW'({mag_in, 3'b000}) + PW'({mag_in, 1'b0}) + PW'(digit);
    assign mag_out = (prod > PW'(CAP)) ? CAP : prod[MAG_WIDTH-1:0];

endmodule

// ----- rtl/core/ocl_scan.sv -----
// Per-character line scanner: token split, keyword/side match, number fields.
module ocl_scan #(
    parameter int MAG_WIDTH = 33
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  char_valid,
    input  logic [7:0]            ch,
    input  logic                  last,
    output ocl_pkg::line_sum_t    sum,
    output logic [MAG_WIDTH-1:0]  mag_id,
    output logic [MAG_WIDTH-1:0]  mag_price,
    output logic [MAG_WIDTH-1:0]  mag_qty,
    output logic                  fire
);
    import ocl_pkg::*;

    localparam logic [MAG_WIDTH-1:0] LIM = {2'b01, {(MAG_WIDTH-2){1'b0}}};

    logic [2:0]           tok_reg, tok_next;
    logic                 inside_reg, inside_next;
    logic                 skip_reg, skip_next;
    logic [2:0]           kw_reg, kw_next;
    logic [2:0]           len_reg, len_next;
    logic [3:0]           side_reg, side_next;
    logic [MAG_WIDTH-1:0] mag_reg [3];
    logic [MAG_WIDTH-1:0] mag_next [3];
    logic [2:0]           neg_reg, neg_next;
    logic [2:0]           seen_reg, seen_next;
    logic [3:0]           err_reg, err_next;

    logic                 blank;
    logic [7:0]           up;
    logic                 is_digit;
    logic                 slot_ok;
    logic [1:0]           slot;
    logic [1:0]           err_bit;
    logic [MAG_WIDTH-1:0] acc_out;

    assign blank    = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0D) || (ch == 8'h0A);
    assign up       = ((ch >= 8'h61) && (ch <= 8'h7A)) ? (ch - 8'h20) : ch;
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign slot_ok  = (tok_reg == TOK_ID) || (tok_reg == TOK_PRICE) || (tok_reg == TOK_QTY);
    assign slot     = (tok_reg == TOK_ID) ? 2'd0 : ((tok_reg == TOK_PRICE) ? 2'd1 : 2'd2);
    assign err_bit  = (slot == 2'd0) ? EB_ID : ((slot == 2'd1) ? EB_PRICE : EB_QTY);

    ocl_dacc #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_dacc (
        .mag_in  (mag_reg[slot]),
        .digit   (ch[3:0]),
        .mag_out (acc_out)
    );

    always_comb begin
        logic           hash;
        logic [2:0]     pos;
        logic           fin;
        logic [MAG_WIDTH-1:0] m;
        logic           over;
        tok_next    = tok_reg;
        inside_next = inside_reg;
        skip_next   = skip_reg;
        kw_next     = kw_reg;
        len_next    = len_reg;
        side_next   = side_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        err_next    = err_reg;
        hash        = 1'b0;
        pos         = 3'd0;
        m           = '0;
        over        = 1'b0;

        // take the character
        if (char_valid && !skip_reg && !blank) begin
            if (!inside_reg) begin
                inside_next = 1'b1;
                len_next    = 3'd0;
                if ((tok_reg == TOK_CMD) && (ch == CH_HASH)) begin
                    skip_next = 1'b1;
                    hash      = 1'b1;
                end
            end
            if (!hash) begin
                pos = len_next;
                if (tok_reg == TOK_CMD) begin
                    for (int i = 0; i < 3; i++) begin
                        if ((pos >= KW_LEN[i]) || (up != KW_CH[i][pos])) begin
                            kw_next[i] = 1'b0;
                        end
                    end
                end else if (tok_reg == TOK_SIDE) begin
                    for (int i = 0; i < 4; i++) begin
                        if ((pos >= SIDE_LEN[i]) || (up != SIDE_CH[i][pos])) begin
                            side_next[i] = 1'b0;
                        end
                    end
                end else if (slot_ok) begin
                    if ((ch == CH_MINUS) && (pos == 3'd0)) begin
                        neg_next[slot] = 1'b1;
                    end else if (is_digit) begin
                        seen_next[slot] = 1'b1;
                        mag_next[slot]  = acc_out;
                    end else begin
                        err_next[err_bit] = 1'b1;
                    end
                end
                if (len_next != TOK_MAX) begin
                    len_next = len_next + 3'd1;
                end
            end
        end

        // close the token on a separator or at the line end
        fin = char_valid && !skip_next && inside_next && (blank || last);
        if (fin) begin
            if (tok_next == TOK_CMD) begin
                for (int i = 0; i < 3; i++) begin
                    if (len_next != KW_LEN[i]) kw_next[i] = 1'b0;
                end
            end else if (tok_next == TOK_SIDE) begin
                for (int i = 0; i < 4; i++) begin
                    if (len_next != SIDE_LEN[i]) side_next[i] = 1'b0;
                end
                if (side_next == 4'd0) err_next[EB_SIDE] = 1'b1;
            end else if (slot_ok) begin
                m    = mag_next[slot];
                over = neg_next[slot] ? (m > LIM) : (m >= LIM);
                if (!seen_next[slot] || over) err_next[err_bit] = 1'b1;
            end
            if (tok_next != TOK_MAX) tok_next = tok_next + 3'd1;
            inside_next = 1'b0;
            len_next    = 3'd0;
        end

        sum.tok   = tok_next;
        sum.skip  = skip_next;
        sum.kw    = kw_next;
        sum.side  = side_next;
        sum.neg   = neg_next;
        sum.err   = err_next;
        mag_id    = mag_next[0];
        mag_price = mag_next[1];
        mag_qty   = mag_next[2];
        fire      = char_valid && last && !skip_next && (tok_next != TOK_CMD);

        // every line starts clean
        if (char_valid && last) begin
            tok_next    = TOK_CMD;
            inside_next = 1'b0;
            skip_next   = 1'b0;
            kw_next     = '1;
            len_next    = 3'd0;
            side_next   = '1;
            for (int i = 0; i < 3; i++) mag_next[i] = '0;
            neg_next    = '0;
            seen_next   = '0;
            err_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= TOK_CMD;
            inside_reg <= 1'b0;
            skip_reg   <= 1'b0;
            kw_reg     <= '1;
            len_reg    <= 3'd0;
            side_reg   <= '1;
            for (int i = 0; i < 3; i++) mag_reg[i] <= '0;
            neg_reg    <= '0;
            seen_reg   <= '0;
            err_reg    <= '0;
        end else begin
            tok_reg    <= tok_next;
            inside_reg <= inside_next;
            skip_reg   <= skip_next;
            kw_reg     <= kw_next;
            len_reg    <= len_next;
            side_reg   <= side_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            seen_reg   <= seen_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ----- rtl/core/ocl_result.sv -----
// End-of-line decode: command, missing/bad field priority, signed values.
module ocl_result #(
    parameter int MAG_WIDTH = 33
) (
    input  ocl_pkg::line_sum_t   sum,
    input  logic [MAG_WIDTH-1:0] mag_id,
    input  logic [MAG_WIDTH-1:0] mag_price,
    input  logic [MAG_WIDTH-1:0] mag_qty,
    output ocl_pkg::result_t     res
);
    import ocl_pkg::*;

    localparam int EW = (MAG_WIDTH > 32) ? MAG_WIDTH : 32;

    logic [EW-1:0] ext_id, ext_price, ext_qty;
    logic [EW-1:0] val_id, val_price, val_qty;

    assign ext_id    = EW'(mag_id);
    assign ext_price = EW'(mag_price);
    assign ext_qty   = EW'(mag_qty);
    assign val_id    = sum.neg[0] ? (~ext_id + EW'(1))    : ext_id;
    assign val_price = sum.neg[1] ? (~ext_price + EW'(1)) : ext_price;
    assign val_qty   = sum.neg[2] ? (~ext_qty + EW'(1))   : ext_qty;

    always_comb begin
        res            = '0;
        res.event_kind = EV_ERROR;
        res.error_code = ERR_NONE;
        if (sum.kw[KW_ADD]) begin
            if (sum.tok < 3'd5)             res.error_code = ERR_MISSING;
            else if (sum.err[EB_ID])        res.error_code = ERR_ID;
            else if (sum.err[EB_SIDE])      res.error_code = ERR_SIDE;
            else if (sum.err[EB_PRICE])     res.error_code = ERR_PRICE;
            else if (sum.err[EB_QTY])       res.error_code = ERR_QTY;
            else begin
                res.event_kind = EV_ADD;
                res.order_id   = val_id[31:0];
                res.side       = sum.side[2] | sum.side[3];   // SELL or S
                res.price      = val_price[31:0];
                res.quantity   = val_qty[31:0];
            end
        end else if (sum.kw[KW_CANCEL]) begin
            if (sum.tok < 3'd2)             res.error_code = ERR_MISSING;
            else if (sum.err[EB_ID])        res.error_code = ERR_ID;
            else begin
                res.event_kind = EV_CANCEL;
                res.order_id   = val_id[31:0];
            end
        end else if (sum.kw[KW_PRINT]) begin
            res.event_kind = EV_PRINT;
        end else begin
            res.error_code = ERR_UNKNOWN;
        end
    end

endmodule

// ----- rtl/core/order_command_line_parser.sv -----
// Top level of the order command line parser: input stage, scanner, result register.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------------
//  input   | s_tvalid s_tready  | s_tdata = one character, s_tlast = line end
//  result  | m_tvalid m_tready  | m_tdata = code and values, m_tuser = event kind
//
// Rate: one character per clock while no line end is held (see Stalls). A character is accepted
// into the input stage and scanned out of it at the next edge, unless it is a held line end; a
// line's result enters the output register at the edge that scans its line end.
// Reset: aresetn low for one clock clears the line state and both valid flags.
// Stalls: characters keep flowing while a result waits; only a line-end character
// waits in the input stage (s_tready low) while the previous result is held by
// m_tready low.
module order_command_line_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] ch
    input  logic         s_tlast,    // line_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // [2:0] error_code, [34:3] order_id, [35] side,
                                     // [67:36] price, [99:68] quantity, [103:100] zero
    output logic [1:0]   m_tuser     // [1:0] event_kind
);
    import ocl_pkg::*;

    localparam int MAG_WIDTH = VALUE_WIDTH + 1;

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;
    logic       adv;

    // result register
    logic       m_valid_reg, m_valid_next;
    result_t    m_data_reg;
    logic       out_free;

    line_sum_t            sum;
    logic [MAG_WIDTH-1:0] mag_id, mag_price, mag_qty;
    logic                 fire;
    result_t              res;

    // checker terms on the registered result
    logic       out_is_err;
    logic       out_no_code;
    logic       out_no_vals;

    // result slot is empty or drains at this edge
    assign out_free = !m_valid_reg || m_tready;

    // a line end moves on only when the result slot is free or draining
    assign adv = in_valid_reg && (!in_last_reg || out_free);
    // a new request is taken whenever the stage is empty or moves on this cycle
    assign s_tready = !in_valid_reg || adv;

    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !adv);
    assign m_valid_next  = (m_valid_reg && !m_tready) || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire) begin
            m_data_reg <= res;
        end
    end

    ocl_scan #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (adv),
        .ch         (in_ch_reg),
        .last       (in_last_reg),
        .sum        (sum),
        .mag_id     (mag_id),
        .mag_price  (mag_price),
        .mag_qty    (mag_qty),
        .fire       (fire)
    );

    ocl_result #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_result (
        .sum       (sum),
        .mag_id    (mag_id),
        .mag_price (mag_price),
        .mag_qty   (mag_qty),
        .res       (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.event_kind;
    assign m_tdata  = {4'b0000, m_data_reg.quantity, m_data_reg.price, m_data_reg.side,
                       m_data_reg.order_id, m_data_reg.error_code};

    assign out_is_err  = (m_data_reg.event_kind == EV_ERROR);
    assign out_no_code = (m_data_reg.error_code == ERR_NONE);
    assign out_no_vals = (m_data_reg.order_id == 32'sd0) && (m_data_reg.price == 32'sd0) &&
                         (m_data_reg.quantity == 32'sd0) && !m_data_reg.side;

`include "order_command_line_parser_defines.svh"

    // a good event never carries an error code
    `OCL_ASSERT_IMP(a_ok_no_code, m_valid_reg && !out_is_err, out_no_code, "event with error code")

    // an error carries a code and no values
    `OCL_ASSERT_IMP(a_err_clean, m_valid_reg && out_is_err, !out_no_code && out_no_vals, "error with values")

    // a result only appears after a line end is scanned
    `OCL_ASSERT_NXT(a_no_spurious, out_free && !(adv && in_last_reg), !m_valid_reg, "result without line end")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the order command line parser: directed lines, then random lines.
`timescale 1ns / 1ps

module tb_top;
    import ocl_pkg::*;

    // Number of random characters after the directed table.
    localparam int RAND_CHARS = 580;

    // MAG_LIMIT is just above the largest legal positive magnitude; parsing saturates at MAG_CAP.
    localparam longint unsigned MAG_LIMIT = 64'd2147483648;
    localparam longint unsigned MAG_CAP   = 64'd2147483649;

    // Clock, reset and block ports. Every input is known from time zero.
    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;     // [7:0] ch
    logic         s_tlast  = 1'b0;      // line_end
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;              // [2:0] error_code, [34:3] order_id, [35] side,
                                        // [67:36] price, [99:68] quantity, [103:100] zero
    logic [1:0]   m_tuser;              // [1:0] event_kind

    order_command_line_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Line parser model: its own copy of the per-line scan state.
    // ------------------------------------------------------------------
    string kw_word   [3] = '{"ADD", "CANCEL", "PRINT"};
    string side_word [4] = '{"BUY", "B", "SELL", "S"};

    logic [2:0]  tok_count;     // tokens closed so far, saturating
    logic        in_token;
    logic        comment_line;  // first token began with '#'
    logic [2:0]  kw_live;       // keywords still matching the first token
    logic [2:0]  tok_len;       // chars in the current token, saturating at 7
    logic [3:0]  side_live;     // side words still matching the third token
    logic [32:0] mag [3];       // id, price, quantity magnitudes
    logic [2:0]  neg_seen;
    logic [2:0]  digit_seen;
    logic [3:0]  field_bad;     // indexed by the EB_* bits

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    // Numeric slot of a token position: id, price, quantity, or none.
    function automatic int num_slot(logic [2:0] t);
        if (t == TOK_ID)    return 0;
        if (t == TOK_PRICE) return 1;
        if (t == TOK_QTY)   return 2;
        return -1;
    endfunction

    function automatic int slot_err_bit(int s);
        if (s == 0) return EB_ID;
        if (s == 1) return EB_PRICE;
        return EB_QTY;
    endfunction

    // Two's complement of a parsed value, cut to the 32-bit output field.
    function automatic logic [31:0] field_value(int s);
        logic [31:0] m;
        m = mag[s][31:0];
        return neg_seen[s] ? -m : m;
    endfunction

    task automatic clear_line();
        tok_count    = TOK_CMD;
        in_token     = 1'b0;
        comment_line = 1'b0;
        kw_live      = 3'b111;
        tok_len      = '0;
        side_live    = 4'b1111;
        for (int i = 0; i < 3; i++) mag[i] = '0;
        neg_seen     = '0;
        digit_seen   = '0;
        field_bad    = '0;
    endtask

    task automatic close_token();
        int s;
        bit ok;
        s = num_slot(tok_count);
        if (tok_count == TOK_CMD) begin
            for (int i = 0; i < 3; i++)
                if (tok_len != kw_word[i].len()) kw_live[i] = 1'b0;
        end else if (tok_count == TOK_SIDE) begin
            for (int i = 0; i < 4; i++)
                if (tok_len != side_word[i].len()) side_live[i] = 1'b0;
            if (side_live == 4'b0000) field_bad[EB_SIDE] = 1'b1;
        end else if (s >= 0) begin
            ok = digit_seen[s];
            // the negative side reaches one step further
            if (neg_seen[s] ? (mag[s] > MAG_LIMIT) : (mag[s] >= MAG_LIMIT)) ok = 1'b0;
            if (!ok) field_bad[slot_err_bit(s)] = 1'b1;
        end
        if (tok_count != TOK_MAX) tok_count++;
        in_token = 1'b0;
        tok_len  = '0;
    endtask

    task automatic take_char(input logic [7:0] c);
        logic [7:0]      up;
        int              s;
        int              pos;
        longint unsigned m;
        longint unsigned d;
        if (comment_line) return;
        if (is_blank(c)) begin
            if (in_token) close_token();
            return;
        end
        if (!in_token) begin
            in_token = 1'b1;
            tok_len  = '0;
            if (tok_count == TOK_CMD && c == CH_HASH) begin
                comment_line = 1'b1;
                return;
            end
        end
        pos = tok_len;
        up  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        s   = num_slot(tok_count);
        if (tok_count == TOK_CMD) begin
            for (int i = 0; i < 3; i++)
                if (pos >= kw_word[i].len() || up != kw_word[i][pos]) kw_live[i] = 1'b0;
        end else if (tok_count == TOK_SIDE) begin
            for (int i = 0; i < 4; i++)
                if (pos >= side_word[i].len() || up != side_word[i][pos]) side_live[i] = 1'b0;
        end else if (s >= 0) begin
            if (c == CH_MINUS && pos == 0) begin
                neg_seen[s] = 1'b1;
            end else if (c >= "0" && c <= "9") begin
                d = c - 8'h30;
                m = mag[s];
                digit_seen[s] = 1'b1;
                if (m > (MAG_CAP - d) / 10) mag[s] = 33'(MAG_CAP);
                else mag[s] = 33'(m * 10 + d);
            end else begin
                field_bad[slot_err_bit(s)] = 1'b1;
            end
        end
        if (tok_len != 3'd7) tok_len++;
    endtask

    // Feed one accepted character; on line end, say whether an event is due.
    task automatic parse_char(input logic [7:0] c, input logic last,
                              output bit got, output result_t ev);
        take_char(c);
        got = 1'b0;
        ev  = '0;
        if (!last) return;
        if (in_token && !comment_line) close_token();
        if (!comment_line && tok_count != TOK_CMD) begin
            got = 1'b1;
            ev.event_kind = EV_ERROR;
            ev.error_code = ERR_NONE;
            if (kw_live[KW_ADD]) begin
                // a missing field beats every bad value
                if (tok_count <= TOK_QTY)      ev.error_code = ERR_MISSING;
                else if (field_bad[EB_ID])     ev.error_code = ERR_ID;
                else if (field_bad[EB_SIDE])   ev.error_code = ERR_SIDE;
                else if (field_bad[EB_PRICE])  ev.error_code = ERR_PRICE;
                else if (field_bad[EB_QTY])    ev.error_code = ERR_QTY;
                else begin
                    ev.event_kind = EV_ADD;
                    ev.order_id   = field_value(0);
                    ev.side       = |side_live[3:2];
                    ev.price      = field_value(1);
                    ev.quantity   = field_value(2);
                end
            end else if (kw_live[KW_CANCEL]) begin
                if (tok_count < TOK_SIDE)      ev.error_code = ERR_MISSING;
                else if (field_bad[EB_ID])     ev.error_code = ERR_ID;
                else begin
                    ev.event_kind = EV_CANCEL;
                    ev.order_id   = field_value(0);
                end
            end else if (kw_live[KW_PRINT]) begin
                ev.event_kind = EV_PRINT;
            end else begin
                ev.error_code = ERR_UNKNOWN;
            end
        end
        clear_line();
    endtask

    // ------------------------------------------------------------------
    // Directed table: one line per row. Typed rows carry their own event.
    // ------------------------------------------------------------------
    typedef struct {
        string   text;
        bit      typed;
        bit      has_ev;
        result_t ev;
    } line_row_t;

    line_row_t dir_lines[$];

    function automatic void typed_row(string text, bit has_ev, logic [1:0] kind,
                                      logic [2:0] code, logic [31:0] id, logic sd,
                                      logic [31:0] pr, logic [31:0] qt);
        line_row_t r;
        r.text  = text;
        r.typed = 1'b1;
        r.has_ev = has_ev;
        r.ev = '0;
        r.ev.event_kind = kind;
        r.ev.error_code = code;
        r.ev.order_id   = id;
        r.ev.side       = sd;
        r.ev.price      = pr;
        r.ev.quantity   = qt;
        dir_lines.push_back(r);
    endfunction

    function automatic void open_row(string text);
        line_row_t r;
        r.text   = text;
        r.typed  = 1'b0;
        r.has_ev = 1'b0;
        r.ev     = '0;
        dir_lines.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Request driver and scoreboard state
    // ------------------------------------------------------------------
    result_t    pending_events[$];      // events owed by the block, oldest first
    logic [7:0] line_q[$];              // characters of the line being built
    logic [7:0] blank_set [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  row_typed;
    bit  row_has_ev;
    result_t row_ev;

    int  err_cnt    = 0;
    int  chars_sent = 0;
    int  lines_sent = 0;
    int  kind_cnt [4] = '{0, 0, 0, 0};

    // One character request; the model runs on the edge that takes it.
    task automatic send_char(input logic [7:0] c, input logic last);
        bit      got;
        result_t ev;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
        parse_char(c, last, got, ev);
        if (last) begin
            if (row_typed) begin
                got = row_has_ev;
                ev  = row_ev;
            end
            if (got) pending_events.push_back(ev);
            lines_sent++;
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_char(line_q[i], i == line_q.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Line building blocks for the random part
    // ------------------------------------------------------------------
    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    // One separator, sometimes a run of them.
    task automatic put_gap();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1;
        repeat (n) line_q.push_back(blank_set[$urandom_range(3)]);
    endtask

    // A word in random letter case.
    task automatic put_word(string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
            line_q.push_back(c);
        end
    endtask

    // A decimal number, mostly legal, sometimes at or past the range edges.
    task automatic put_number();
        int     r;
        longint v;
        r = $urandom_range(99);
        if (r < 40) begin
            v = $urandom_range(999);
            if ($urandom_range(3) == 0) v = -v;
        end else if (r < 70) begin
            v = int'($urandom());
        end else if (r < 80) begin
            v = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        end else if (r < 88) begin
            put_text("00");
            v = $urandom_range(99);
        end else if (r < 95) begin
            // just past the range on either side
            v = 64'sd2147483648 + $urandom_range(1000);
            if ($urandom_range(1)) v = -(v + 1);
        end else begin
            v = longint'({$urandom(), $urandom()}) & 64'h7FFF_FFFF_FFFF_FFFF;
        end
        put_text($sformatf("%0d", v));
    endtask

    // A token that no side field accepts, nor a numeric one unless its random first byte is a digit or minus.
    task automatic put_junk();
        int         r;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 20) begin
            put_text("-");
        end else if (r < 40) begin
            put_text($sformatf("--%0d", $urandom_range(99)));
        end else if (r < 60) begin
            put_text($sformatf("%0dq", $urandom_range(99)));
        end else if (r < 80) begin
            put_text($sformatf("+%0d", $urandom_range(99)));
        end else begin
            b = 8'($urandom_range(255));
            if (is_blank(b)) b = "z";
            line_q.push_back(b);
            put_text($sformatf("%0d", $urandom_range(9)));
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: random back-pressure, compare against oldest event
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin : result_mon
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected event: expected none, got kind %0d data %h",
                             $time, m_tuser, m_tdata);
                    err_cnt++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", want.event_kind, m_tuser);
                    check_field("error_code", want.error_code, m_tdata[2:0]);
                    check_field("order_id",   want.order_id,   m_tdata[34:3]);
                    check_field("side",       want.side,       m_tdata[35]);
                    check_field("price",      want.price,      m_tdata[67:36]);
                    check_field("quantity",   want.quantity,   m_tdata[99:68]);
                    check_field("pad",        '0,              m_tdata[103:100]);
                    kind_cnt[m_tuser]++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int dir_chars;
        int r;
        int n;
        int bad_slot;
        int n_fields;
        int phase;
        logic [7:0] b;

        // Legal extremes, each error code, blank and comment lines.
        typed_row("PRINT", 1, EV_PRINT, ERR_NONE, 0, 0, 0, 0);
        typed_row("add 1 buy 10 20", 1, EV_ADD, ERR_NONE, 1, 0, 10, 20);
        typed_row("Cancel 7", 1, EV_CANCEL, ERR_NONE, 7, 0, 0, 0);
        typed_row(" ", 0, EV_ADD, ERR_NONE, 0, 0, 0, 0);
        typed_row("#ADD 1 B 2 3", 0, EV_ADD, ERR_NONE, 0, 0, 0, 0);
        typed_row("FOO 1", 1, EV_ERROR, ERR_UNKNOWN, 0, 0, 0, 0);
        typed_row("ADD 1 B 2", 1, EV_ERROR, ERR_MISSING, 0, 0, 0, 0);
        typed_row("CANCEL", 1, EV_ERROR, ERR_MISSING, 0, 0, 0, 0);
        typed_row("ADD x1 S 2 3", 1, EV_ERROR, ERR_ID, 0, 0, 0, 0);
        typed_row("ADD 1 SX 2 3", 1, EV_ERROR, ERR_SIDE, 0, 0, 0, 0);
        typed_row("ADD 1 s 2-1 3", 1, EV_ERROR, ERR_PRICE, 0, 0, 0, 0);
        typed_row("ADD 1 sell 2 -", 1, EV_ERROR, ERR_QTY, 0, 0, 0, 0);
        typed_row("ADD 2147483647 SELL -2147483648 -1", 1, EV_ADD, ERR_NONE,
                  32'h7FFF_FFFF, 1, 32'h8000_0000, 32'hFFFF_FFFF);
        typed_row("ADD 2147483648 B 1 1", 1, EV_ERROR, ERR_ID, 0, 0, 0, 0);
        typed_row("CANCEL -2147483649", 1, EV_ERROR, ERR_ID, 0, 0, 0, 0);
        typed_row("ADD x B 1", 1, EV_ERROR, ERR_MISSING, 0, 0, 0, 0);
        // The rest goes through the model.
        open_row("ADD 1 B 99999999999999999999 1");
        open_row("\tPRINT extra tokens\r\n");
        open_row("aDd 5 b 6 7 8 9 10 11");
        open_row("ADDX 1 B 2 3");
        open_row("PRIN");
        open_row("1 # 2");
        open_row("CANCEL --5");
        open_row("cancel -0 \n");
        open_row("ADD -0 S 007 -00 \t");
        open_row("ADD 1 BUYS 2 3");
        open_row("\r\n\t # comment after blanks");

        clear_line();
        row_typed     = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 67;

        // Single reset pulse, never repeated.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_lines[i]) begin
            row_typed  = dir_lines[i].typed;
            row_has_ev = dir_lines[i].has_ev;
            row_ev     = dir_lines[i].ev;
            line_q.delete();
            put_text(dir_lines[i].text);
            send_line();
        end
        row_typed = 1'b0;
        dir_chars = chars_sent;

        // Random lines: mostly well-formed commands with random content,
        // then unknown words, comments, blank lines and raw byte noise.
        while (chars_sent < dir_chars + RAND_CHARS) begin
            // idle mix: sender light / receiver heavy, swapped, then none
            phase = (chars_sent - dir_chars) * 3 / RAND_CHARS;
            if (phase == 0) begin
                send_idle_pct = 17;
                recv_idle_pct = 67;
            end else if (phase == 1) begin
                send_idle_pct = 67;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            line_q.delete();
            if ($urandom_range(4) == 0) put_gap();
            r = $urandom_range(99);
            if (r < 45) begin
                // ADD: sometimes short of fields, sometimes one field broken
                bad_slot = ($urandom_range(5) == 0) ? $urandom_range(4, 1) : 0;
                n_fields = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
                put_word("ADD");
                for (int f = 1; f <= n_fields; f++) begin
                    put_gap();
                    if (f == bad_slot) put_junk();
                    else if (f == 2) put_word(side_word[$urandom_range(3)]);
                    else put_number();
                end
                if ($urandom_range(4) == 0) begin
                    put_gap();
                    put_junk();
                end
            end else if (r < 65) begin
                put_word("CANCEL");
                if ($urandom_range(9) != 0) begin
                    put_gap();
                    if ($urandom_range(7) == 0) put_junk();
                    else put_number();
                end
                if ($urandom_range(4) == 0) begin
                    put_gap();
                    put_number();
                end
            end else if (r < 75) begin
                put_word("PRINT");
                if ($urandom_range(3) == 0) begin
                    put_gap();
                    put_junk();
                end
            end else if (r < 80) begin
                put_text("#");
                put_word("ADD");
                put_gap();
                put_number();
            end else if (r < 85) begin
                put_gap();
            end else if (r < 90) begin
                // near-miss keyword: one char short or one too many
                n = $urandom_range(2);
                if ($urandom_range(1))
                    put_word(kw_word[n].substr(0, kw_word[n].len() - 2));
                else
                    put_word({kw_word[n], "X"});
                put_gap();
                put_number();
            end else begin
                n = $urandom_range(16, 1);
                repeat (n) begin
                    b = 8'($urandom_range(255));
                    line_q.push_back(b);
                end
            end
            if ($urandom_range(2) == 0) put_gap();
            send_line();
        end
        s_tvalid <= 1'b0;

        // Drain, then a short tail to catch stray events.
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d lines, %0d chars; events: %0d add, %0d cancel, %0d print, %0d error.",
                 lines_sent, chars_sent, kind_cnt[EV_ADD], kind_cnt[EV_CANCEL],
                 kind_cnt[EV_PRINT], kind_cnt[EV_ERROR]);
        $display("Idle mix ran sender-light, receiver-light, then gap-free traffic.");
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ocl_pkg.sv
rtl/core/ocl_dacc.sv
rtl/core/ocl_scan.sv
rtl/core/ocl_result.sv
rtl/core/order_command_line_parser.sv
verif/tb_top.sv
